/* hdl/idru_pkg.sv */
// ----------------------------------------------------------------------------
// idru_pkg
// Shared types, codes and widths for the pipelined integer divide unit.
// ----------------------------------------------------------------------------
package idru_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CMD_WIDTH  = 2;
  localparam int STS_WIDTH  = 2;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_SDIV = 2'd0,
    CMD_UDIV = 2'd1,
    CMD_SREM = 2'd2,
    CMD_UREM = 2'd3
  } cmd_t;

  typedef enum logic [STS_WIDTH-1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // one beat moving down the divide pipeline
  typedef struct packed {
    logic    vld;
    logic    is_rem;
    logic    neg_res;
    status_t status;
    word_t   rem;
    word_t   quo;
    word_t   dvs;
  } stage_t;

endpackage

/* hdl/idru_prep.sv */
// ----------------------------------------------------------------------------
// idru_prep
// Operand decode: exception checks, operand magnitudes, result sign.
// ----------------------------------------------------------------------------
module idru_prep (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic [idru_pkg::CMD_WIDTH-1:0]      in_command,
  input  logic [idru_pkg::DATA_WIDTH-1:0]     in_dividend,
  input  logic [idru_pkg::DATA_WIDTH-1:0]     in_divisor,
  output idru_pkg::stage_t                    stage_r
);
  import idru_pkg::*;

  localparam word_t SIGN_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  cmd_t   cmd;
  logic   is_signed;
  logic   na;
  logic   nb;
  stage_t stage_nxt;

  always_comb begin
    cmd       = cmd_t'(in_command);
    is_signed = (cmd == CMD_SDIV) || (cmd == CMD_SREM);
    na        = is_signed && in_dividend[DATA_WIDTH-1];
    nb        = is_signed && in_divisor[DATA_WIDTH-1];

    stage_nxt         = '0;
    stage_nxt.vld     = in_vld;
    stage_nxt.is_rem  = (cmd == CMD_SREM) || (cmd == CMD_UREM);
    stage_nxt.neg_res = stage_nxt.is_rem ? na : (na ^ nb);
    if (in_divisor == '0) begin
      stage_nxt.status = ST_DIV_ZERO;
    end else if (is_signed && (in_dividend == SIGN_MIN) && (&in_divisor)) begin
      stage_nxt.status = ST_OVERFLOW;
    end else begin
      stage_nxt.status = ST_OK;
    end
    // quotient register starts out holding the dividend magnitude
    stage_nxt.rem = '0;
    stage_nxt.quo = na ? (~in_dividend + 1'b1) : in_dividend;
    stage_nxt.dvs = nb ? (~in_divisor + 1'b1) : in_divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else begin
      stage_r.vld <= stage_nxt.vld;
    end
    stage_r.is_rem  <= stage_nxt.is_rem;
    stage_r.neg_res <= stage_nxt.neg_res;
    stage_r.status  <= stage_nxt.status;
    stage_r.rem     <= stage_nxt.rem;
    stage_r.quo     <= stage_nxt.quo;
    stage_r.dvs     <= stage_nxt.dvs;
  end

endmodule

/* hdl/idru_step.sv */
// ----------------------------------------------------------------------------
// idru_step
// One restoring divide iteration: shift in a dividend bit, trial subtract,
// produce one quotient bit.
// ----------------------------------------------------------------------------
module idru_step (
  input  logic             clk,
  input  logic             rst_n,
  input  idru_pkg::stage_t stage_in,
  output idru_pkg::stage_t stage_r
);
  import idru_pkg::*;

  logic [DATA_WIDTH:0] shifted;
  logic [DATA_WIDTH:0] trial;
  logic                qbit;
  stage_t              stage_nxt;

  always_comb begin
    shifted   = {stage_in.rem, stage_in.quo[DATA_WIDTH-1]};
    trial     = shifted - {1'b0, stage_in.dvs};
    qbit      = ~trial[DATA_WIDTH];
    stage_nxt = stage_in;
    // partial remainder stays below the divisor, so it fits one word
    stage_nxt.rem = qbit ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    stage_nxt.quo = {stage_in.quo[DATA_WIDTH-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else begin
      stage_r.vld <= stage_nxt.vld;
    end
    stage_r.is_rem  <= stage_nxt.is_rem;
    stage_r.neg_res <= stage_nxt.neg_res;
    stage_r.status  <= stage_nxt.status;
    stage_r.rem     <= stage_nxt.rem;
    stage_r.quo     <= stage_nxt.quo;
    stage_r.dvs     <= stage_nxt.dvs;
  end

endmodule

/* hdl/idru_post.sv */
// ----------------------------------------------------------------------------
// idru_post
// Result select, sign fix-up and exception masking into the output register.
// ----------------------------------------------------------------------------
module idru_post (
  input  logic                            clk,
  input  logic                            rst_n,
  input  idru_pkg::stage_t                stage_in,
  output logic                            out_strobe,
  output logic [idru_pkg::DATA_WIDTH-1:0] out_result_bits,
  output logic [idru_pkg::STS_WIDTH-1:0]  out_status
);
  import idru_pkg::*;

  logic    strobe_r;
  word_t   result_r;
  status_t status_r;
  word_t   mag;
  word_t   result_nxt;

  always_comb begin
    mag = stage_in.is_rem ? stage_in.rem : stage_in.quo;
    if (stage_in.status != ST_OK) begin
      result_nxt = '0;
    end else if (stage_in.neg_res) begin
      result_nxt = ~mag + 1'b1;
    end else begin
      result_nxt = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= stage_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    status_r <= stage_in.status;
  end

  assign out_strobe      = strobe_r;
  assign out_result_bits = result_r;
  assign out_status      = status_r;

endmodule

/* hdl/int32_divide_remainder_unit.sv */
// ----------------------------------------------------------------------------
// int32_divide_remainder_unit
// Pipelined signed/unsigned 32-bit divide and remainder unit.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_command, in_dividend and in_divisor and raise start for one
//   cycle per request. busy is always low, so a request is taken at every
//   edge where start is high: one beat per cycle, back to back.
//   Each request gives exactly one result, shown on out_result_bits and
//   out_status for one cycle while out_strobe is high. Results leave in the
//   order the requests came in.
//   Pipeline: 34 register stages (one decode stage, one stage per quotient
//   bit, one output stage); a request passes through them in that order,
//   and the outputs are driven from the output stage.
//   Throughput: one result per cycle, set by the one-bit-per-stage
//   restoring divider array.
//   Divide by zero gives 0 with status 1; a signed command with the most
//   negative dividend over minus one gives 0 with status 2.
//   Reset clears all valid bits; results in flight are dropped. The
//   receiver has no way to stall the outputs.
// ----------------------------------------------------------------------------
module int32_divide_remainder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [idru_pkg::CMD_WIDTH-1:0]  in_command,
  input  logic [idru_pkg::DATA_WIDTH-1:0] in_dividend,
  input  logic [idru_pkg::DATA_WIDTH-1:0] in_divisor,
  output logic                            out_strobe,
  output logic [idru_pkg::DATA_WIDTH-1:0] out_result_bits,
  output logic [idru_pkg::STS_WIDTH-1:0]  out_status
);
  import idru_pkg::*;

  stage_t pipe [DATA_WIDTH+1];
  logic   accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  idru_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (accept),
    .in_command  (in_command),
    .in_dividend (in_dividend),
    .in_divisor  (in_divisor),
    .stage_r     (pipe[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    idru_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_in (pipe[i]),
      .stage_r  (pipe[i+1])
    );
  end

  idru_post u_post (
    .clk             (clk),
    .rst_n           (rst_n),
    .stage_in        (pipe[DATA_WIDTH]),
    .out_strobe      (out_strobe),
    .out_result_bits (out_result_bits),
    .out_status      (out_status)
  );

endmodule
